// ===== rtl/cca_pkg.sv =====
package cca_pkg;

  localparam int COORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int          K_W     = 34;
  localparam logic [33:0] K_RESET = 34'd8987551787;

  // quotient bits kept by the dividers; higher bits only raise overflow
  localparam int QW = 64;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  localparam logic [63:0] SIGN64 = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MAX64  = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [31:0] field_x;
    logic [31:0] field_y;
    logic [31:0] field_z;
    logic [31:0] node_x;
    logic [31:0] node_y;
    logic [31:0] node_z;
    logic [31:0] node_weight;
    logic [31:0] panel_area;
    logic        last_node;
  } in_beat_t;

  typedef struct packed {
    logic [63:0] potential;
    logic [63:0] efield_x;
    logic [63:0] efield_y;
    logic [63:0] efield_z;
    logic [1:0]  status;
  } out_beat_t;

  typedef struct packed {
    logic        sat;
    logic [63:0] val;
  } sat_val_t;

  // clamp a magnitude to the signed range and apply the sign
  function automatic sat_val_t sclamp(input logic ovf, input logic [63:0] m,
                                      input logic neg);
    sat_val_t    res;
    logic [63:0] lim;
    logic [63:0] mm;
    lim = neg ? SIGN64 : MAX64;
    mm  = m;
    res.sat = 1'b0;
    if (ovf || (m > lim)) begin
      mm      = lim;
      res.sat = 1'b1;
    end
    res.val = neg ? (64'd0 - mm) : mm;
    return res;
  endfunction

  function automatic sat_val_t sadd(input logic [63:0] a, input logic [63:0] b);
    sat_val_t    res;
    logic [63:0] s;
    s       = a + b;
    res.sat = (~(a[63] ^ b[63])) & (a[63] ^ s[63]);
    res.val = res.sat ? (a[63] ? SIGN64 : MAX64) : s;
    return res;
  endfunction

endpackage

// ===== rtl/coulomb_cubature_accumulator_unit.sv =====
// Weighted point-charge potential and field accumulator. Each input beat
// carries a field point P, one cubature node Q, its Q2.30 weight w and the
// panel area. The unit forms d = P - Q, adds w/|d| to a potential sum and
// w*d/|d|^3 to three field sums; on a beat with last_node set it emits one
// result beat scaled by panel_area * coulomb_constant (Q48.16, saturating)
// and clears its sums. A node on top of the field point is skipped and
// flagged with status 1; any clamp gives status 2. All arithmetic is done
// by bit-serial shift-add multipliers, a bit-per-cycle square root and
// bit-per-cycle restoring dividers, so one beat is in flight at a time.
// The time from one accepted beat to the next is set mostly by the 128-step
// quotient loop of the dividers, and a last beat adds the 64-step output
// scaling multiply and the emit state. A skipped node bypasses the root,
// the cube and the dividers. A finished result sits in an output register,
// so the next beat is taken while it waits; a second result holds the unit
// until the first one has left. The 34-bit coulomb_constant sits at byte
// address 0 of the 64-bit APB port; write it only while idle.
module coulomb_cubature_accumulator_unit #(
  parameter int COORD_BITS = cca_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = cca_pkg::FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  cca_pkg::in_beat_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output cca_pkg::out_beat_t out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [63:0]       pwdata,
  output logic [63:0]       prdata,
  output logic              pready
);

  localparam int CB   = COORD_BITS;
  localparam int SXS  = 64 - COORD_BITS;
  localparam int R2W  = 2 * CB + 2;
  localparam int CMPW = (R2W > 71) ? R2W : 71;
  localparam int NPW  = CB + 32;
  localparam int PSH  = FRAC_BITS + 2;
  localparam int FSH  = 2 * FRAC_BITS + 2;
  localparam int QW   = cca_pkg::QW;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_MUL   = 11'b000_0000_0010,
    S_CHK   = 11'b000_0000_0100,
    S_ROOT  = 11'b000_0000_1000,
    S_CGO   = 11'b000_0001_0000,
    S_CUBE  = 11'b000_0010_0000,
    S_DIV   = 11'b000_0100_0000,
    S_ACC   = 11'b000_1000_0000,
    S_POST  = 11'b001_0000_0000,
    S_SCALE = 11'b010_0000_0000,
    S_EMIT  = 11'b100_0000_0000
  } state_t;

  state_t state_r;

  // configuration
  logic [cca_pkg::K_W-1:0] k_r;
  logic                    cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && !paddr[3];
  assign prdata = paddr[3] ? 64'd0 : 64'(k_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= cca_pkg::K_RESET;
    end else if (cfg_wr) begin
      k_r <= pwdata[cca_pkg::K_W-1:0];
    end
  end

  // input decode: sign-extend coordinates, take differences and magnitudes
  logic        in_acc;
  logic [63:0] pt_ext [6];
  logic [63:0] dif    [3];
  logic [CB-1:0] dm   [3];
  logic [2:0]  dneg;
  logic [31:0] wm;
  logic        wneg;

  assign in_acc = in_valid && !in_stall;

  always_comb begin
    pt_ext[0] = $signed({32'd0, in_data.field_x} << SXS) >>> SXS;
    pt_ext[1] = $signed({32'd0, in_data.field_y} << SXS) >>> SXS;
    pt_ext[2] = $signed({32'd0, in_data.field_z} << SXS) >>> SXS;
    pt_ext[3] = $signed({32'd0, in_data.node_x} << SXS) >>> SXS;
    pt_ext[4] = $signed({32'd0, in_data.node_y} << SXS) >>> SXS;
    pt_ext[5] = $signed({32'd0, in_data.node_z} << SXS) >>> SXS;
    for (int i = 0; i < 3; i++) begin
      dif[i]  = pt_ext[i] - pt_ext[3+i];
      dneg[i] = dif[i][63];
      dm[i]   = dneg[i] ? CB'(64'd0 - dif[i]) : CB'(dif[i]);
    end
    wneg = in_data.node_weight[31];
    wm   = wneg ? (32'd0 - in_data.node_weight) : in_data.node_weight;
  end

  // per-beat context
  logic [2:0]  dneg_r;
  logic [31:0] wm_r;
  logic        wneg_r;
  logic        last_r;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      dneg_r <= dneg;
      wm_r   <= wm;
      wneg_r <= wneg;
      last_r <= in_data.last_node;
    end
  end

  // squares, weight-times-distance numerators, and the area scale
  logic [2:0]       sq_busy;
  logic [2:0]       np_busy;
  logic [2*CB-1:0]  sq_p [3];
  logic [NPW-1:0]   np_p [3];
  logic             ka_busy;
  logic [65:0]      ka_p;

  for (genvar g = 0; g < 3; g++) begin : g_lane_mul
    cca_smul #(.AW(CB), .BW(CB)) u_sq (
      .clk(clk), .rst_n(rst_n), .start(in_acc), .a(dm[g]), .b(dm[g]),
      .busy(sq_busy[g]), .prod(sq_p[g])
    );
    cca_smul #(.AW(CB), .BW(32)) u_np (
      .clk(clk), .rst_n(rst_n), .start(in_acc), .a(dm[g]), .b(wm),
      .busy(np_busy[g]), .prod(np_p[g])
    );
  end

  cca_smul #(.AW(cca_pkg::K_W), .BW(32)) u_ka (
    .clk(clk), .rst_n(rst_n), .start(in_acc), .a(k_r), .b(in_data.panel_area),
    .busy(ka_busy), .prod(ka_p)
  );

  // squared distance and integer square root, one result bit per cycle
  logic [R2W-1:0] r2_r;
  logic [34:0]    res_r;
  logic [69:0]    sqr_r;
  logic [70:0]    t1_r;
  logic [69:0]    t2_r;
  logic [34:0]    bit_r;
  logic [70:0]    cand;
  logic           take;
  logic [70:0]    t1_up;

  assign cand  = 71'(sqr_r) + t1_r + 71'(t2_r);
  assign take  = CMPW'(r2_r) >= CMPW'(cand);
  assign t1_up = take ? (t1_r + {t2_r, 1'b0}) : t1_r;

  // cube of the root and the four dividers
  logic           cube_start;
  logic           cube_busy;
  logic [104:0]   cube_p;
  logic           pdiv_start;
  logic           fdiv_start;
  logic [3:0]     dv_busy;
  logic [QW-1:0]  dv_q [4];
  logic [3:0]     dv_ovf;
  logic [127:0]   pot_num;

  assign cube_start = (state_r == S_CGO);
  assign pdiv_start = (state_r == S_CGO);
  assign fdiv_start = (state_r == S_CUBE) && !cube_busy;
  assign pot_num    = 128'(wm_r) << PSH;

  cca_smul #(.AW(70), .BW(35)) u_cube (
    .clk(clk), .rst_n(rst_n), .start(cube_start), .a(sqr_r), .b(res_r),
    .busy(cube_busy), .prod(cube_p)
  );

  cca_sdiv #(.NW(128), .DW(35)) u_pdiv (
    .clk(clk), .rst_n(rst_n), .start(pdiv_start), .num(pot_num), .den(res_r),
    .busy(dv_busy[0]), .quo(dv_q[0]), .ovf(dv_ovf[0])
  );

  for (genvar g = 0; g < 3; g++) begin : g_fdiv
    cca_sdiv #(.NW(128), .DW(105)) u_fdiv (
      .clk(clk), .rst_n(rst_n), .start(fdiv_start),
      .num(128'(np_p[g]) << FSH), .den(cube_p),
      .busy(dv_busy[g+1]), .quo(dv_q[g+1]), .ovf(dv_ovf[g+1])
    );
  end

  // accumulate: clamp each term, saturating add into the running sums
  logic [63:0]         sum_r [4];
  logic [1:0]          rstat_r;
  logic [3:0]          tneg;
  cca_pkg::sat_val_t   term  [4];
  cca_pkg::sat_val_t   nsum  [4];
  logic                acc_sat;

  // term signs: weight sign for the potential, weight xor d sign for a field
  assign tneg = {dneg_r ^ {3{wneg_r}}, wneg_r};

  always_comb begin
    acc_sat = 1'b0;
    for (int i = 0; i < 4; i++) begin
      term[i] = cca_pkg::sclamp(dv_ovf[i], dv_q[i], tneg[i]);
      nsum[i] = cca_pkg::sadd(sum_r[i], term[i].val);
      acc_sat = acc_sat | term[i].sat | nsum[i].sat;
    end
  end

  // output scaling: |sum| * K * area, keep bits 95:32
  logic           sc_start;
  logic [3:0]     sc_busy;
  logic [129:0]   sc_p [4];
  logic [63:0]    smag [4];
  cca_pkg::sat_val_t ov [4];
  logic           osat;

  assign sc_start = (state_r == S_POST) && last_r;

  for (genvar g = 0; g < 4; g++) begin : g_scale
    assign smag[g] = sum_r[g][63] ? (64'd0 - sum_r[g]) : sum_r[g];
    cca_smul #(.AW(66), .BW(64)) u_sc (
      .clk(clk), .rst_n(rst_n), .start(sc_start), .a(ka_p), .b(smag[g]),
      .busy(sc_busy[g]), .prod(sc_p[g])
    );
  end

  always_comb begin
    osat = 1'b0;
    for (int i = 0; i < 4; i++) begin
      ov[i] = cca_pkg::sclamp(sc_p[i][129:96] != 34'd0, sc_p[i][95:32],
                              sum_r[i][63]);
      osat  = osat | ov[i].sat;
    end
  end

  // output register
  logic               out_valid_r;
  cca_pkg::out_beat_t out_data_r;
  logic               out_free;
  logic               emit;

  assign out_free  = !out_valid_r || !out_stall;
  assign emit      = (state_r == S_EMIT) && out_free;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign in_stall  = (state_r != S_IDLE);

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      rstat_r     <= cca_pkg::ST_OK;
      for (int i = 0; i < 4; i++) begin
        sum_r[i] <= '0;
      end
    end else begin
      // load a new beat, or drop the one the receiver just took
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          // wait for the serial multipliers, then sum the squares
          if ((sq_busy == 3'd0) && (np_busy == 3'd0) && !ka_busy) begin
            r2_r    <= R2W'(sq_p[0]) + R2W'(sq_p[1]) + R2W'(sq_p[2]);
            state_r <= S_CHK;
          end
        end
        S_CHK: begin
          if (r2_r == '0) begin
            // node on the field point: skip it
            if (rstat_r == cca_pkg::ST_OK) begin
              rstat_r <= cca_pkg::ST_ZERO;
            end
            state_r <= S_POST;
          end else begin
            res_r   <= '0;
            sqr_r   <= '0;
            t1_r    <= '0;
            t2_r    <= 70'd1 << 68;
            bit_r   <= 35'd1 << 34;
            state_r <= S_ROOT;
          end
        end
        S_ROOT: begin
          if (take) begin
            sqr_r <= cand[69:0];
            res_r <= res_r | bit_r;
          end
          t1_r  <= t1_up >> 1;
          t2_r  <= t2_r >> 2;
          bit_r <= bit_r >> 1;
          if (bit_r[0]) begin
            state_r <= S_CGO;
          end
        end
        S_CGO: begin
          state_r <= S_CUBE;
        end
        S_CUBE: begin
          if (!cube_busy) begin
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (dv_busy == 4'd0) begin
            state_r <= S_ACC;
          end
        end
        S_ACC: begin
          for (int i = 0; i < 4; i++) begin
            sum_r[i] <= nsum[i].val;
          end
          if (acc_sat) begin
            rstat_r <= cca_pkg::ST_SAT;
          end
          state_r <= S_POST;
        end
        S_POST: begin
          state_r <= last_r ? S_SCALE : S_IDLE;
        end
        S_SCALE: begin
          if (sc_busy == 4'd0) begin
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          // hold until the output register can take the beat
          if (emit) begin
            out_data_r.potential <= ov[0].val;
            out_data_r.efield_x  <= ov[1].val;
            out_data_r.efield_y  <= ov[2].val;
            out_data_r.efield_z  <= ov[3].val;
            out_data_r.status    <= osat ? cca_pkg::ST_SAT : rstat_r;
            for (int i = 0; i < 4; i++) begin
              sum_r[i] <= '0;
            end
            rstat_r <= cca_pkg::ST_OK;
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/cca_smul.sv =====
// bit-serial unsigned multiplier: one multiplier bit per cycle
module cca_smul #(
  parameter int AW = 32,
  parameter int BW = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic             busy,
  output logic [AW+BW-1:0] prod
);

  localparam int PW = AW + BW;
  localparam int CW = $clog2(BW + 1);

  logic [PW-1:0] mc_r;
  logic [BW-1:0] mp_r;
  logic [PW-1:0] acc_r;
  logic [CW-1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= CW'(BW);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mc_r  <= PW'(a);
      mp_r  <= b;
      acc_r <= '0;
    end else if (cnt_r != '0) begin
      if (mp_r[0]) begin
        acc_r <= acc_r + mc_r;
      end
      mc_r <= mc_r << 1;
      mp_r <= mp_r >> 1;
    end
  end

  assign busy = (cnt_r != '0);
  assign prod = acc_r;

endmodule

// ===== rtl/cca_sdiv.sv =====
// restoring divider: one quotient bit per cycle, low QW bits kept
module cca_sdiv #(
  parameter int NW = 128,
  parameter int DW = 35
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [NW-1:0]         num,
  input  logic [DW-1:0]         den,
  output logic                  busy,
  output logic [cca_pkg::QW-1:0] quo,
  output logic                  ovf
);

  localparam int CW = $clog2(NW + 1);
  localparam int QW = cca_pkg::QW;

  logic [NW-1:0] nsh_r;
  logic [DW-1:0] den_r;
  logic [DW-1:0] rem_r;
  logic [QW-1:0] q_r;
  logic          ovf_r;
  logic [CW-1:0] cnt_r;
  logic [DW:0]   trial;
  logic          ge;
  logic [DW:0]   diff;

  assign trial = {rem_r, nsh_r[NW-1]};
  assign ge    = (trial >= {1'b0, den_r});
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= CW'(NW);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      nsh_r <= num;
      den_r <= den;
      rem_r <= '0;
      q_r   <= '0;
      ovf_r <= 1'b0;
    end else if (cnt_r != '0) begin
      nsh_r <= nsh_r << 1;
      rem_r <= ge ? diff[DW-1:0] : trial[DW-1:0];
      q_r   <= {q_r[QW-2:0], ge};
      ovf_r <= ovf_r | q_r[QW-1];
    end
  end

  assign busy = (cnt_r != '0);
  assign quo  = q_r;
  assign ovf  = ovf_r;

endmodule
